FILE: rtl/debounced_clock_setting_menu_assert.svh
// Assertion macros shared by the clock setting menu modules.
`ifndef DEBOUNCED_CLOCK_SETTING_MENU_ASSERT_SVH
`define DEBOUNCED_CLOCK_SETTING_MENU_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DCSM_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clock setting menu check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define DCSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clock setting menu check failed");

`endif

FILE: rtl/dcsm_pkg.sv
// Types and constants shared by the clock setting menu modules.
package dcsm_pkg;

    localparam int CNT_BITS = 17;
    localparam int CMP_W    = (CNT_BITS > 16) ? CNT_BITS : 16;
    localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

    localparam logic [15:0] DEBOUNCE_RESET = 16'd50;

    localparam logic [4:0] HOUR24_TOP = 5'd23;
    localparam logic [4:0] HOUR12_TOP = 5'd12;
    localparam logic [5:0] MINUTE_TOP = 6'd59;
    localparam logic [2:0] WDAY_TOP   = 3'd7;
    localparam logic [4:0] DATE_TOP   = 5'd31;
    localparam logic [3:0] MONTH_TOP  = 4'd12;
    localparam logic [6:0] YEAR_TOP   = 7'd99;

    typedef enum logic {
        OP_TICK,
        OP_LOAD
    } opcode_t;

    typedef enum logic [1:0] {
        REC_TIME,
        REC_ALARM1,
        REC_ALARM2
    } rec_sel_t;

    typedef enum logic [2:0] {
        DISP_SHOW_TIME,
        DISP_SHOW_ALARM1,
        DISP_SHOW_ALARM2,
        DISP_SET_TIME,
        DISP_SET_ALARM1,
        DISP_SET_ALARM2
    } disp_t;

    typedef enum logic [1:0] {
        SET_NONE,
        SET_MOVE,
        SET_CHANGE
    } set_t;

    typedef enum logic [2:0] {
        FLD_HOUR,
        FLD_MINUTE,
        FLD_SECOND,
        FLD_PM,
        FLD_WDAY,
        FLD_DATE,
        FLD_MONTH,
        FLD_YEAR
    } field_t;

    typedef enum logic [2:0] {
        REQ_NONE,
        REQ_READ_TIME,
        REQ_READ_ALARM1,
        REQ_READ_ALARM2,
        REQ_WRITE_TIME,
        REQ_WRITE_ALARM1,
        REQ_WRITE_ALARM2
    } req_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] wday;
        logic [4:0] date;
        logic [3:0] month;
        logic [6:0] year;
        logic       pm;
        logic       twelve;
    } rec_t;

    typedef struct packed {
        logic back;
        logic center;
        logic right;
    } press_t;

    typedef struct packed {
        disp_t  display_mode;
        set_t   setting_mode;
        field_t field_target;
        req_t   clock_request;
        rec_t   shown;
    } res_t;

endpackage

FILE: rtl/dcsm_lane.sv
// Debounce lane for one active-low button: hold counter, stable level, press detect.
module dcsm_lane
    import dcsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        level,
    input  logic [15:0] debounce_samples,
    output logic        press
);

    logic                prev_reg;
    logic                stable_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                stable_next;
    logic                fire;

    always_comb
    begin
        if (level != prev_reg)
        begin
            count_next = '0;
        end
        else if (count_reg == CNT_MAX)
        begin
            count_next = count_reg;
        end
        else
        begin
            count_next = count_reg + {{(CNT_BITS-1){1'b0}}, 1'b1};
        end
        fire        = (CMP_W'(count_next) > CMP_W'(debounce_samples)) && (level != stable_reg);
        stable_next = fire ? level : stable_reg;
        press       = en && fire && !level;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= 1'b0;
            stable_reg <= 1'b0;
            count_reg  <= '0;
        end
        else if (en)
        begin
            prev_reg   <= level;
            stable_reg <= stable_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/dcsm_menu.sv
// Menu merge stage: applies the lanes' presses in order and holds the three records.
`include "debounced_clock_setting_menu_assert.svh"

module dcsm_menu
    import dcsm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     load,
    input  press_t   presses,
    input  rec_sel_t record_select,
    input  rec_t     load_rec,
    output res_t     result
);

    disp_t  disp_reg, disp_next;
    set_t   set_reg, set_next;
    field_t fld_reg, fld_next;
    req_t   req_next;
    rec_t   time_reg, time_next;
    rec_t   al1_reg, al1_next;
    rec_t   al2_reg, al2_next;

    function automatic rec_t bump(rec_t r, field_t f, rec_sel_t sel);
        rec_t n;
        begin
            n = r;
            case (f)
                FLD_HOUR:
                begin
                    if (r.twelve)
                    begin
                        n.hour = (r.hour >= HOUR12_TOP) ? 5'd1 : r.hour + 5'd1;
                    end
                    else
                    begin
                        n.hour = (r.hour >= HOUR24_TOP) ? 5'd0 : r.hour + 5'd1;
                    end
                end
                FLD_MINUTE:
                begin
                    n.minute = (r.minute >= MINUTE_TOP) ? 6'd0 : r.minute + 6'd1;
                end
                FLD_SECOND:
                begin
                    if (sel != REC_ALARM2)
                    begin
                        n.second = 6'd0;
                    end
                end
                FLD_PM:
                begin
                    n.pm = ~r.pm;
                end
                FLD_WDAY:
                begin
                    n.wday = (r.wday >= WDAY_TOP) ? 3'd1 : r.wday + 3'd1;
                end
                FLD_DATE:
                begin
                    n.date = (r.date >= DATE_TOP) ? 5'd1 : r.date + 5'd1;
                end
                FLD_MONTH:
                begin
                    if (sel == REC_TIME)
                    begin
                        n.month = (r.month >= MONTH_TOP) ? 4'd1 : r.month + 4'd1;
                    end
                end
                default:
                begin
                    if (sel == REC_TIME)
                    begin
                        n.year = (r.year >= YEAR_TOP) ? 7'd0 : r.year + 7'd1;
                    end
                end
            endcase
            return n;
        end
    endfunction

    // Next state: back, then center, then right, then a record load.
    always_comb
    begin
        disp_next = disp_reg;
        set_next  = set_reg;
        fld_next  = fld_reg;
        req_next  = REQ_NONE;
        time_next = time_reg;
        al1_next  = al1_reg;
        al2_next  = al2_reg;

        if (presses.back)
        begin
            case (set_next)
                SET_NONE:
                begin
                    disp_next = DISP_SHOW_TIME;
                end
                SET_CHANGE:
                begin
                    set_next = SET_MOVE;
                    case (disp_next)
                        DISP_SET_TIME:   req_next = REQ_WRITE_TIME;
                        DISP_SET_ALARM1: req_next = REQ_WRITE_ALARM1;
                        DISP_SET_ALARM2: req_next = REQ_WRITE_ALARM2;
                        default:         req_next = req_next;
                    endcase
                end
                SET_MOVE:
                begin
                    set_next = SET_NONE;
                    case (disp_next)
                        DISP_SET_TIME:   disp_next = DISP_SHOW_TIME;
                        DISP_SET_ALARM1: disp_next = DISP_SHOW_ALARM1;
                        DISP_SET_ALARM2: disp_next = DISP_SHOW_ALARM2;
                        default:         disp_next = disp_next;
                    endcase
                end
                default:
                begin
                    set_next = set_next;
                end
            endcase
        end

        if (presses.center)
        begin
            case (set_next)
                SET_NONE:
                begin
                    case (disp_next)
                        DISP_SHOW_TIME:
                        begin
                            disp_next = DISP_SET_TIME;
                            set_next  = SET_MOVE;
                        end
                        DISP_SHOW_ALARM1:
                        begin
                            disp_next = DISP_SET_ALARM1;
                            set_next  = SET_MOVE;
                        end
                        DISP_SHOW_ALARM2:
                        begin
                            disp_next = DISP_SET_ALARM2;
                            set_next  = SET_MOVE;
                        end
                        default:
                        begin
                            disp_next = disp_next;
                        end
                    endcase
                end
                SET_MOVE:
                begin
                    set_next = SET_CHANGE;
                end
                default:
                begin
                    set_next = set_next;
                end
            endcase
        end

        if (presses.right)
        begin
            case (set_next)
                SET_NONE:
                begin
                    case (disp_next)
                        DISP_SHOW_TIME:
                        begin
                            req_next  = REQ_READ_ALARM1;
                            disp_next = DISP_SHOW_ALARM1;
                        end
                        DISP_SHOW_ALARM1:
                        begin
                            req_next  = REQ_READ_ALARM2;
                            disp_next = DISP_SHOW_ALARM2;
                        end
                        DISP_SHOW_ALARM2:
                        begin
                            req_next  = REQ_READ_TIME;
                            disp_next = DISP_SHOW_TIME;
                        end
                        default:
                        begin
                            disp_next = disp_next;
                        end
                    endcase
                end
                SET_CHANGE:
                begin
                    case (disp_next)
                        DISP_SET_TIME:   time_next = bump(time_reg, fld_next, REC_TIME);
                        DISP_SET_ALARM1: al1_next  = bump(al1_reg, fld_next, REC_ALARM1);
                        DISP_SET_ALARM2: al2_next  = bump(al2_reg, fld_next, REC_ALARM2);
                        default:         time_next = time_reg;
                    endcase
                end
                SET_MOVE:
                begin
                    if (fld_next == FLD_DATE)
                    begin
                        if (disp_next == DISP_SET_ALARM1 || disp_next == DISP_SET_ALARM2)
                        begin
                            fld_next = FLD_HOUR;
                        end
                        else
                        begin
                            fld_next = FLD_MONTH;
                        end
                    end
                    else
                    begin
                        fld_next = field_t'(fld_next + 3'd1);
                    end
                end
                default:
                begin
                    set_next = set_next;
                end
            endcase
        end

        if (load)
        begin
            case (record_select)
                REC_TIME:
                begin
                    time_next = load_rec;
                end
                REC_ALARM1:
                begin
                    al1_next       = load_rec;
                    al1_next.month = al1_reg.month;
                    al1_next.year  = al1_reg.year;
                end
                REC_ALARM2:
                begin
                    al2_next       = load_rec;
                    al2_next.month = al2_reg.month;
                    al2_next.year  = al2_reg.year;
                end
                default:
                begin
                    time_next = time_reg;
                end
            endcase
        end
    end

    // Outputs: the state after this transaction.
    always_comb
    begin
        result.display_mode  = disp_next;
        result.setting_mode  = set_next;
        result.field_target  = fld_next;
        result.clock_request = req_next;
        case (disp_next)
            DISP_SHOW_ALARM1, DISP_SET_ALARM1: result.shown = al1_next;
            DISP_SHOW_ALARM2, DISP_SET_ALARM2: result.shown = al2_next;
            default:                           result.shown = time_next;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_reg <= DISP_SHOW_TIME;
            set_reg  <= SET_NONE;
            fld_reg  <= FLD_HOUR;
            time_reg <= '0;
            al1_reg  <= '0;
            al2_reg  <= '0;
        end
        else if (en)
        begin
            disp_reg <= disp_next;
            set_reg  <= set_next;
            fld_reg  <= fld_next;
            time_reg <= time_next;
            al1_reg  <= al1_next;
            al2_reg  <= al2_next;
        end
    end

    `DCSM_ASSERT_IMPLIES(a_setting_in_set_view, set_reg != SET_NONE,
        disp_reg == DISP_SET_TIME || disp_reg == DISP_SET_ALARM1 || disp_reg == DISP_SET_ALARM2)
    `DCSM_ASSERT_IMPLIES(a_idle_in_show_view, set_reg == SET_NONE,
        disp_reg == DISP_SHOW_TIME || disp_reg == DISP_SHOW_ALARM1 ||
        disp_reg == DISP_SHOW_ALARM2)
    `DCSM_ASSERT_IMPLIES(a_alarm_month_year_zero, 1'b1,
        al1_reg.month == 4'd0 && al1_reg.year == 7'd0 &&
        al2_reg.month == 4'd0 && al2_reg.year == 7'd0)

endmodule

FILE: rtl/debounced_clock_setting_menu.sv
// Top level of the debounced clock setting menu: lanes, menu stage and output register.
//
// Input channel (in_valid/in_ready): one transaction per button sample tick (opcode 0)
// or per record load (opcode 1). A tick feeds the three button levels to three debounce
// lanes that work side by side; the menu stage applies their presses in the order back,
// center, right. A load writes the record chosen by record_select (alarms keep month, year).
// Output channel (out_valid/out_ready): exactly one transaction per input transaction,
// showing modes, selected field, clock request and the shown record after that item.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes debounce_samples; it is
// always ready. Write it only while no transaction is in flight.
// The result is registered and is valid in the cycle after the input transaction is accepted.
// Throughput: one transaction per cycle while the output is not stalled, set by the
// combinational lane-and-menu path into the output register.
// When the receiver stalls, the output register holds its result and in_ready stays high
// only when that register is empty or being drained the same cycle.
// Reset clears modes, debounce lanes and all records to zero, debounce_samples to 50,
// and empties the output register.
`include "debounced_clock_setting_menu_assert.svh"

module debounced_clock_setting_menu
    import dcsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [2:0]  button_levels,
    input  logic [1:0]  record_select,
    input  logic [4:0]  load_hour,
    input  logic [5:0]  load_minute,
    input  logic [5:0]  load_second,
    input  logic [2:0]  load_wday,
    input  logic [4:0]  load_date,
    input  logic [3:0]  load_month,
    input  logic [6:0]  load_year,
    input  logic        load_pm,
    input  logic        load_twelve_hour,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  display_mode,
    output logic [1:0]  setting_mode,
    output logic [2:0]  field_target,
    output logic [2:0]  clock_request,
    output logic [4:0]  shown_hour,
    output logic [5:0]  shown_minute,
    output logic [5:0]  shown_second,
    output logic [2:0]  shown_wday,
    output logic [4:0]  shown_date,
    output logic [3:0]  shown_month,
    output logic [6:0]  shown_year,
    output logic [1:0]  shown_flags
);

    logic [15:0] debounce_reg;
    logic        valid_reg, valid_next;
    res_t        out_reg;
    res_t        result;
    logic        accept;
    logic        tick;
    logic        load;
    logic [2:0]  press_bits;
    press_t      presses;
    rec_t        load_rec;

    assign cfg_ready = 1'b1;
    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign tick      = accept && (opcode == OP_TICK);
    assign load      = accept && (opcode == OP_LOAD);

    genvar i;
    generate
        for (i = 0; i < 3; i++)
        begin : g_lane
            dcsm_lane u_lane (
                .clk              (clk),
                .rst_n            (rst_n),
                .en               (tick),
                .level            (button_levels[i]),
                .debounce_samples (debounce_reg),
                .press            (press_bits[i])
            );
        end
    endgenerate

    assign presses.back   = press_bits[0];
    assign presses.center = press_bits[1];
    assign presses.right  = press_bits[2];

    always_comb
    begin
        load_rec.hour   = load_hour;
        load_rec.minute = load_minute;
        load_rec.second = load_second;
        load_rec.wday   = load_wday;
        load_rec.date   = load_date;
        load_rec.month  = load_month;
        load_rec.year   = load_year;
        load_rec.pm     = load_pm;
        load_rec.twelve = load_twelve_hour;
    end

    dcsm_menu u_menu (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (accept),
        .load          (load),
        .presses       (presses),
        .record_select (rec_sel_t'(record_select)),
        .load_rec      (load_rec),
        .result        (result)
    );

    assign valid_next = accept || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            valid_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_valid && cfg_ready)
            begin
                debounce_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= result;
        end
    end

    assign out_valid     = valid_reg;
    assign display_mode  = out_reg.display_mode;
    assign setting_mode  = out_reg.setting_mode;
    assign field_target  = out_reg.field_target;
    assign clock_request = out_reg.clock_request;
    assign shown_hour    = out_reg.shown.hour;
    assign shown_minute  = out_reg.shown.minute;
    assign shown_second  = out_reg.shown.second;
    assign shown_wday    = out_reg.shown.wday;
    assign shown_date    = out_reg.shown.date;
    assign shown_month   = out_reg.shown.month;
    assign shown_year    = out_reg.shown.year;
    assign shown_flags   = {out_reg.shown.twelve, out_reg.shown.pm};

    `DCSM_ASSERT_IMPLIES(a_write_req_matches_view,
        valid_reg && (out_reg.clock_request == REQ_WRITE_TIME ||
        out_reg.clock_request == REQ_WRITE_ALARM1 || out_reg.clock_request == REQ_WRITE_ALARM2),
        3'(out_reg.display_mode + 3'd1) == out_reg.clock_request)
    `DCSM_ASSERT_NEXT(a_load_gives_no_request, load,
        valid_reg && out_reg.clock_request == REQ_NONE)

endmodule

FILE: verif/tb_debounced_clock_setting_menu.sv
// Self-checking testbench for the clock setting menu: directed table, then random traffic.
module tb_debounced_clock_setting_menu
    import dcsm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        opcode_t    op;
        logic [2:0] lv;
        logic [1:0] rsel;
        rec_t       ld;
    } in_item_t;

    typedef struct {
        bit          is_cfg;
        logic [15:0] cfg_val;
        in_item_t    it;
        bit          has_exp;
        res_t        exp;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic [2:0]  button_levels;
    logic [1:0]  record_select;
    logic [4:0]  load_hour;
    logic [5:0]  load_minute;
    logic [5:0]  load_second;
    logic [2:0]  load_wday;
    logic [4:0]  load_date;
    logic [3:0]  load_month;
    logic [6:0]  load_year;
    logic        load_pm;
    logic        load_twelve_hour;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  display_mode;
    logic [1:0]  setting_mode;
    logic [2:0]  field_target;
    logic [2:0]  clock_request;
    logic [4:0]  shown_hour;
    logic [5:0]  shown_minute;
    logic [5:0]  shown_second;
    logic [2:0]  shown_wday;
    logic [4:0]  shown_date;
    logic [3:0]  shown_month;
    logic [6:0]  shown_year;
    logic [1:0]  shown_flags;

    // predictor state
    logic [15:0]         dbnc;
    disp_t               mdisp;
    set_t                mset;
    field_t              fsel;
    req_t                req;
    logic [2:0]          prev_lv;
    logic [2:0]          stab_lv;
    logic [CNT_BITS-1:0] held [3];
    rec_t                recs [3];

    res_t        views_due [$];
    row_t        plan [$];
    int          mismatches = 0;
    int          phase_items;
    int          send_idle_pct = 17;
    int          recv_idle_pct = 78;
    int unsigned phase_dbnc [9] = '{0, 2, 7, 1, 0, 50, 3, 1, 0};

    debounced_clock_setting_menu i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .button_levels    (button_levels),
        .record_select    (record_select),
        .load_hour        (load_hour),
        .load_minute      (load_minute),
        .load_second      (load_second),
        .load_wday        (load_wday),
        .load_date        (load_date),
        .load_month       (load_month),
        .load_year        (load_year),
        .load_pm          (load_pm),
        .load_twelve_hour (load_twelve_hour),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .display_mode     (display_mode),
        .setting_mode     (setting_mode),
        .field_target     (field_target),
        .clock_request    (clock_request),
        .shown_hour       (shown_hour),
        .shown_minute     (shown_minute),
        .shown_second     (shown_second),
        .shown_wday       (shown_wday),
        .shown_date       (shown_date),
        .shown_month      (shown_month),
        .shown_year       (shown_year),
        .shown_flags      (shown_flags)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [6:0] step_wrap(logic [6:0] v, logic [6:0] top,
                                             logic [6:0] bottom);
        return (v >= top) ? bottom : 7'(v + 7'd1);
    endfunction

    function automatic void apply_back();
        if (mset == SET_NONE)
        begin
            mdisp = DISP_SHOW_TIME;
        end
        else if (mset == SET_CHANGE)
        begin
            mset = SET_MOVE;
            if (mdisp >= DISP_SET_TIME && mdisp <= DISP_SET_ALARM2)
                req = req_t'(3'(mdisp + 3'd1));
        end
        else if (mset == SET_MOVE)
        begin
            mset = SET_NONE;
            if (mdisp >= DISP_SET_TIME && mdisp <= DISP_SET_ALARM2)
                mdisp = disp_t'(3'(mdisp - 3'd3));
        end
    endfunction

    function automatic void apply_center();
        if (mset == SET_NONE)
        begin
            if (mdisp <= DISP_SHOW_ALARM2)
            begin
                mdisp = disp_t'(3'(mdisp + 3'd3));
                mset  = SET_MOVE;
            end
        end
        else if (mset == SET_MOVE)
        begin
            mset = SET_CHANGE;
        end
    endfunction

    function automatic void bump_field();
        int r;
        if (mdisp < DISP_SET_TIME || mdisp > DISP_SET_ALARM2)
            return;
        r = int'(mdisp) - int'(DISP_SET_TIME);
        case (fsel)
            FLD_HOUR:
                if (recs[r].twelve)
                    recs[r].hour = 5'(step_wrap(7'(recs[r].hour), 7'(HOUR12_TOP), 7'd1));
                else
                    recs[r].hour = 5'(step_wrap(7'(recs[r].hour), 7'(HOUR24_TOP), 7'd0));
            FLD_MINUTE:
                recs[r].minute = 6'(step_wrap(7'(recs[r].minute), 7'(MINUTE_TOP), 7'd0));
            FLD_SECOND:
                if (r != int'(REC_ALARM2))
                    recs[r].second = '0;
            FLD_PM:
                recs[r].pm = ~recs[r].pm;
            FLD_WDAY:
                recs[r].wday = 3'(step_wrap(7'(recs[r].wday), 7'(WDAY_TOP), 7'd1));
            FLD_DATE:
                recs[r].date = 5'(step_wrap(7'(recs[r].date), 7'(DATE_TOP), 7'd1));
            FLD_MONTH:
                if (r == int'(REC_TIME))
                    recs[r].month = 4'(step_wrap(7'(recs[r].month), 7'(MONTH_TOP), 7'd1));
            default:
                if (r == int'(REC_TIME))
                    recs[r].year = step_wrap(recs[r].year, YEAR_TOP, 7'd0);
        endcase
    endfunction

    function automatic void apply_right();
        if (mset == SET_NONE)
        begin
            case (mdisp)
                DISP_SHOW_TIME:
                begin
                    req   = REQ_READ_ALARM1;
                    mdisp = DISP_SHOW_ALARM1;
                end
                DISP_SHOW_ALARM1:
                begin
                    req   = REQ_READ_ALARM2;
                    mdisp = DISP_SHOW_ALARM2;
                end
                DISP_SHOW_ALARM2:
                begin
                    req   = REQ_READ_TIME;
                    mdisp = DISP_SHOW_TIME;
                end
                default: ;
            endcase
        end
        else if (mset == SET_CHANGE)
        begin
            bump_field();
        end
        else if (mset == SET_MOVE)
        begin
            if (fsel == FLD_DATE)
                fsel = (mdisp == DISP_SET_ALARM1 || mdisp == DISP_SET_ALARM2) ?
                       FLD_HOUR : FLD_MONTH;
            else
                fsel = field_t'(3'(fsel + 3'd1));
        end
    endfunction

    function automatic res_t menu_step(in_item_t it);
        res_t view;
        rec_t tmp;
        logic lvl;
        req = REQ_NONE;
        if (it.op == OP_TICK)
        begin
            for (int b = 0; b < 3; b++)
            begin
                lvl = it.lv[b];
                if (lvl != prev_lv[b])
                    held[b] = '0;
                else if (held[b] < CNT_MAX)
                    held[b] = held[b] + 1'b1;
                if (held[b] > dbnc && lvl != stab_lv[b])
                begin
                    stab_lv[b] = lvl;
                    if (!lvl)
                    begin
                        if (b == 0)
                            apply_back();
                        else if (b == 1)
                            apply_center();
                        else
                            apply_right();
                    end
                end
                prev_lv[b] = lvl;
            end
        end
        else if (it.rsel <= REC_ALARM2)
        begin
            tmp = it.ld;
            if (it.rsel != REC_TIME)
            begin
                tmp.month = recs[it.rsel].month;
                tmp.year  = recs[it.rsel].year;
            end
            recs[it.rsel] = tmp;
        end
        view.display_mode  = mdisp;
        view.setting_mode  = mset;
        view.field_target  = fsel;
        view.clock_request = req;
        if (mdisp == DISP_SHOW_ALARM1 || mdisp == DISP_SET_ALARM1)
            view.shown = recs[REC_ALARM1];
        else if (mdisp == DISP_SHOW_ALARM2 || mdisp == DISP_SET_ALARM2)
            view.shown = recs[REC_ALARM2];
        else
            view.shown = recs[REC_TIME];
        return view;
    endfunction

    function automatic rec_t rand_rec();
        rec_t r;
        case ($urandom_range(3))
            0:       r.hour = HOUR24_TOP;
            1:       r.hour = HOUR12_TOP;
            default: r.hour = 5'($urandom_range(23));
        endcase
        r.minute = ($urandom_range(3) == 0) ? MINUTE_TOP : 6'($urandom_range(59));
        r.second = 6'($urandom_range(59));
        r.wday   = ($urandom_range(3) == 0) ? WDAY_TOP : 3'($urandom_range(7, 1));
        r.date   = ($urandom_range(3) == 0) ? DATE_TOP : 5'($urandom_range(31, 1));
        r.month  = ($urandom_range(3) == 0) ? MONTH_TOP : 4'($urandom_range(12, 1));
        r.year   = ($urandom_range(3) == 0) ? YEAR_TOP : 7'($urandom_range(99));
        r.pm     = 1'($urandom_range(1));
        r.twelve = 1'($urandom_range(1));
        return r;
    endfunction

    function automatic in_item_t make_item(opcode_t op, logic [2:0] lv);
        in_item_t it;
        it.op   = op;
        it.lv   = lv;
        it.rsel = 2'($urandom_range(3));
        it.ld   = rand_rec();
        return it;
    endfunction

    function automatic row_t item_row(in_item_t it);
        row_t rw;
        rw.is_cfg  = 1'b0;
        rw.cfg_val = '0;
        rw.it      = it;
        rw.has_exp = 1'b0;
        rw.exp     = '0;
        return rw;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("%0t ns: %s", $time, what);
    endtask

    task automatic check_field(string name, logic [6:0] got, logic [6:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task automatic send_item(in_item_t it, bit typed, res_t typed_view);
        res_t view;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid         <= 1'b1;
        opcode           <= it.op;
        button_levels    <= it.lv;
        record_select    <= it.rsel;
        load_hour        <= it.ld.hour;
        load_minute      <= it.ld.minute;
        load_second      <= it.ld.second;
        load_wday        <= it.ld.wday;
        load_date        <= it.ld.date;
        load_month       <= it.ld.month;
        load_year        <= it.ld.year;
        load_pm          <= it.ld.pm;
        load_twelve_hour <= it.ld.twelve;
        do
            @(posedge clk);
        while (!in_ready);
        view = menu_step(it);
        views_due.push_back(typed ? typed_view : view);
        phase_items++;
        @(negedge clk);
    endtask

    task automatic drain_views();
        in_valid <= 1'b0;
        @(negedge clk);
        while (views_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_debounce(logic [15:0] value);
        drain_views();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        dbnc = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(int n_items);
        bit         drained;
        int         r;
        int         len;
        logic [2:0] pat;
        phase_items = 0;
        drained     = 1'b0;
        while (phase_items < n_items)
        begin
            if (!drained && phase_items >= n_items / 2)
            begin
                drain_views();
                drained = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 12)
            begin
                send_item(make_item(OP_LOAD, 3'($urandom)), 1'b0, '0);
            end
            else
            begin
                if (r < 25)
                begin
                    pat = 3'($urandom_range(7));
                    len = $urandom_range(int'(dbnc) + 1, 1);
                end
                else
                begin
                    len = int'(dbnc) + 2 + $urandom_range(2);
                    if (stab_lv != 3'b111)
                        pat = 3'b111;
                    else
                    begin
                        r = $urandom_range(99);
                        if (r < 20)
                            pat = 3'b110;
                        else if (r < 50)
                            pat = 3'b101;
                        else if (r < 90)
                            pat = 3'b011;
                        else
                            pat = 3'($urandom_range(6));
                    end
                end
                repeat (len)
                begin
                    if ($urandom_range(99) < 4)
                        send_item(make_item(OP_LOAD, 3'($urandom)), 1'b0, '0);
                    send_item(make_item(OP_TICK, pat), 1'b0, '0);
                end
            end
        end
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (views_due.size() == 0)
            begin
                report_mismatch("result with no transaction outstanding");
            end
            else
            begin
                want = views_due.pop_front();
                check_field("display_mode", 7'(display_mode), 7'(want.display_mode));
                check_field("setting_mode", 7'(setting_mode), 7'(want.setting_mode));
                check_field("field_target", 7'(field_target), 7'(want.field_target));
                check_field("clock_request", 7'(clock_request), 7'(want.clock_request));
                check_field("shown_hour", 7'(shown_hour), 7'(want.shown.hour));
                check_field("shown_minute", 7'(shown_minute), 7'(want.shown.minute));
                check_field("shown_second", 7'(shown_second), 7'(want.shown.second));
                check_field("shown_wday", 7'(shown_wday), 7'(want.shown.wday));
                check_field("shown_date", 7'(shown_date), 7'(want.shown.date));
                check_field("shown_month", 7'(shown_month), 7'(want.shown.month));
                check_field("shown_year", 7'(shown_year), want.shown.year);
                check_field("shown_flags", 7'(shown_flags),
                            7'({want.shown.twelve, want.shown.pm}));
            end
        end
    end

    initial
    begin
        rec_t       top_rec;
        rec_t       alarm_rec;
        res_t       time_view;
        row_t       rw;
        in_item_t   it;
        logic [2:0] seq [10];

        rst_n            <= 1'b0;
        cfg_valid        <= 1'b0;
        cfg_data         <= '0;
        in_valid         <= 1'b0;
        opcode           <= OP_TICK;
        button_levels    <= '0;
        record_select    <= REC_TIME;
        load_hour        <= '0;
        load_minute      <= '0;
        load_second      <= '0;
        load_wday        <= '0;
        load_date        <= '0;
        load_month       <= '0;
        load_year        <= '0;
        load_pm          <= 1'b0;
        load_twelve_hour <= 1'b0;

        dbnc    = DEBOUNCE_RESET;
        mdisp   = DISP_SHOW_TIME;
        mset    = SET_NONE;
        fsel    = FLD_HOUR;
        req     = REQ_NONE;
        prev_lv = '0;
        stab_lv = '0;
        for (int b = 0; b < 3; b++)
        begin
            held[b] = '0;
            recs[b] = '0;
        end

        top_rec.hour    = HOUR24_TOP;
        top_rec.minute  = MINUTE_TOP;
        top_rec.second  = MINUTE_TOP;
        top_rec.wday    = WDAY_TOP;
        top_rec.date    = DATE_TOP;
        top_rec.month   = MONTH_TOP;
        top_rec.year    = YEAR_TOP;
        top_rec.pm      = 1'b1;
        top_rec.twelve  = 1'b1;
        time_view       = '0;
        time_view.shown = top_rec;

        alarm_rec        = '0;
        alarm_rec.hour   = HOUR12_TOP;
        alarm_rec.minute = MINUTE_TOP;
        alarm_rec.wday   = 3'd1;
        alarm_rec.date   = 5'd1;
        alarm_rec.month  = MONTH_TOP;
        alarm_rec.year   = YEAR_TOP;
        alarm_rec.twelve = 1'b1;

        rw = item_row(make_item(OP_TICK, 3'b111));
        rw.has_exp = 1'b1;
        rw.exp     = '0;
        plan.push_back(rw);

        it = make_item(OP_LOAD, 3'b000);
        it.rsel = REC_TIME;
        it.ld   = top_rec;
        rw = item_row(it);
        rw.has_exp = 1'b1;
        rw.exp     = time_view;
        plan.push_back(rw);

        // alarm load must leave month and year alone
        it.rsel = REC_ALARM1;
        it.ld   = alarm_rec;
        rw = item_row(it);
        rw.has_exp = 1'b1;
        rw.exp     = time_view;
        plan.push_back(rw);

        // unused record select loads nothing
        it.rsel = 2'd3;
        it.ld   = '0;
        rw = item_row(it);
        rw.has_exp = 1'b1;
        rw.exp     = time_view;
        plan.push_back(rw);

        rw = item_row(it);
        rw.is_cfg  = 1'b1;
        rw.cfg_val = 16'd0;
        plan.push_back(rw);

        seq = '{3'b111, 3'b011, 3'b111, 3'b101, 3'b111,
                3'b000, 3'b111, 3'b001, 3'b111, 3'b110};
        foreach (seq[k])
        begin
            plan.push_back(item_row(make_item(OP_TICK, seq[k])));
            plan.push_back(item_row(make_item(OP_TICK, seq[k])));
        end

        rw = item_row(it);
        rw.is_cfg  = 1'b1;
        rw.cfg_val = 16'hFFFF;
        plan.push_back(rw);
        plan.push_back(item_row(make_item(OP_TICK, 3'b000)));

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_debounce(plan[i].cfg_val);
            else
                send_item(plan[i].it, plan[i].has_exp, plan[i].exp);
        end

        for (int p = 0; p < 9; p++)
        begin
            case (p / 3)
                0:
                begin
                    send_idle_pct = 17;
                    recv_idle_pct = 78;
                end
                1:
                begin
                    send_idle_pct = 78;
                    recv_idle_pct = 17;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_debounce(16'(phase_dbnc[p]));
            run_phase(170);
        end

        drain_views();
        repeat (3) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
